FILE: hw/rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    localparam int unsigned MID_DEPTH = 2;
    localparam int unsigned OUT_DEPTH = 2;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;
    localparam logic [16:0] COUNT_MAX        = 17'h1FFFF;

    localparam logic [15:0] CH_QUOTE   = 16'h0022;
    localparam logic [15:0] CH_BSLASH  = 16'h005C;
    localparam logic [15:0] CH_SLASH   = 16'h002F;
    localparam logic [15:0] CH_U       = 16'h0075;
    localparam logic [15:0] CH_B       = 16'h0062;
    localparam logic [15:0] CH_F       = 16'h0066;
    localparam logic [15:0] CH_N       = 16'h006E;
    localparam logic [15:0] CH_R       = 16'h0072;
    localparam logic [15:0] CH_T       = 16'h0074;
    localparam logic [15:0] CTRL_LIMIT = 16'h0020;

    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_LOW_BS,
        PH_LOW_U,
        PH_LOW_HEX
    } ph_t;

    typedef enum logic [3:0] {
        ST_GO          = 4'd0,
        ST_DONE        = 4'd1,
        ST_NOQUOTE     = 4'd2,
        ST_LONG        = 4'd3,
        ST_ENDS        = 4'd4,
        ST_CTRL        = 4'd5,
        ST_MALFORMED   = 4'd6,
        ST_LONE        = 4'd7,
        ST_UNSUPPORTED = 4'd8
    } st_t;

    typedef struct packed {
        logic        end_of_text;
        logic [15:0] unit;
        logic        is_quote;
        logic        is_bslash;
        logic        is_ctrl;
        logic        is_u;
        logic        is_hex;
        logic [3:0]  hex_val;
        logic        is_simple;
        logic [15:0] simple_unit;
    } item_t;

    typedef struct packed {
        logic [15:0] decoded_unit;
        logic        decoded_valid;
        st_t         status;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/jsu_fifo.sv
`default_nettype none

module jsu_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_front.sv
`default_nettype none

module jsu_front #(
    parameter int unsigned MID_DEPTH = jsu_pkg::MID_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [15:0]   code_unit,
    input  wire logic          end_of_text,
    output jsu_pkg::item_t     item,
    output logic               item_empty,
    input  wire logic          item_pop
);

    jsu_pkg::item_t cls;

    // Each code unit is tagged with everything the decoder needs to know about it.
    always_comb
    begin
        cls             = '0;
        cls.end_of_text = end_of_text;
        cls.unit        = code_unit;
        cls.is_quote    = (code_unit == jsu_pkg::CH_QUOTE);
        cls.is_bslash   = (code_unit == jsu_pkg::CH_BSLASH);
        cls.is_ctrl     = (code_unit < jsu_pkg::CTRL_LIMIT);
        cls.is_u        = (code_unit == jsu_pkg::CH_U);
        if (code_unit inside {[16'h0030:16'h0039]})
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = code_unit[3:0];
        end
        else if (code_unit inside {[16'h0041:16'h0046], [16'h0061:16'h0066]})
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = code_unit[3:0] + 4'd9;
        end
        case (code_unit)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            begin
                cls.is_simple   = 1'b1;
                cls.simple_unit = code_unit;
            end
            jsu_pkg::CH_B:
            begin
                cls.is_simple   = 1'b1;
                cls.simple_unit = 16'h0008;
            end
            jsu_pkg::CH_F:
            begin
                cls.is_simple   = 1'b1;
                cls.simple_unit = 16'h000C;
            end
            jsu_pkg::CH_N:
            begin
                cls.is_simple   = 1'b1;
                cls.simple_unit = 16'h000A;
            end
            jsu_pkg::CH_R:
            begin
                cls.is_simple   = 1'b1;
                cls.simple_unit = 16'h000D;
            end
            jsu_pkg::CH_T:
            begin
                cls.is_simple   = 1'b1;
                cls.simple_unit = 16'h0009;
            end
            default:
            begin
                cls.is_simple   = 1'b0;
                cls.simple_unit = '0;
            end
        endcase
    end

    jsu_fifo #(
        .WIDTH ($bits(jsu_pkg::item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cls),
        .full  (full),
        .pop   (item_pop),
        .dout  (item),
        .empty (item_empty)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_back.sv
`default_nettype none

module jsu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jsu_pkg::item_t item,
    input  wire logic           item_empty,
    output logic                item_pop,
    input  wire logic [15:0]    max_length,
    output jsu_pkg::res_t       res,
    output logic                res_push,
    input  wire logic           res_full
);

    jsu_pkg::ph_t phase_reg;
    jsu_pkg::ph_t phase_next;
    logic [15:0]  acc_reg;
    logic [15:0]  acc_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic [16:0]  count_reg;
    logic [16:0]  count_next;
    logic [16:0]  count_bumped;

    logic         fire;
    logic         plain;
    logic         too_long;
    logic         digit_ok;
    logic         last_digit;
    logic [15:0]  acc_shift;
    logic         in_lo;
    logic         in_hi;

    assign fire         = !item_empty && !res_full;
    assign item_pop     = fire;
    assign res_push     = fire;
    assign count_bumped = (count_reg == jsu_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign plain        = !item.end_of_text && !item.is_quote && !item.is_bslash
                          && !item.is_ctrl;
    assign too_long     = (count_reg > {1'b0, max_length});
    assign digit_ok     = !item.end_of_text && item.is_hex;
    assign last_digit   = (cnt_reg == 2'd3);
    assign acc_shift    = {acc_reg[11:0], item.hex_val};
    assign in_lo        = (acc_shift >= jsu_pkg::SURR_LO_FIRST)
                          && (acc_shift <= jsu_pkg::SURR_LO_LAST);
    assign in_hi        = (acc_shift >= jsu_pkg::SURR_HI_FIRST)
                          && (acc_shift <= jsu_pkg::SURR_HI_LAST);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        count_next = count_reg;
        if (fire)
        begin
            case (phase_reg)
                jsu_pkg::PH_BODY:
                begin
                    if (plain)
                    begin
                        count_next = count_bumped;
                    end
                    else if (too_long || item.end_of_text || !item.is_bslash)
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        phase_next = jsu_pkg::PH_ESC;
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    if (item.end_of_text)
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                    else if (item.is_simple)
                    begin
                        phase_next = jsu_pkg::PH_BODY;
                        count_next = count_bumped;
                    end
                    else if (item.is_u)
                    begin
                        phase_next = jsu_pkg::PH_HEX;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                end
                jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX:
                begin
                    if (!digit_ok)
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        if (!last_digit)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            cnt_next = '0;
                            if (phase_reg == jsu_pkg::PH_HEX)
                            begin
                                if (in_lo)
                                begin
                                    phase_next = jsu_pkg::PH_WAIT;
                                end
                                else
                                begin
                                    phase_next = in_hi ? jsu_pkg::PH_LOW_BS : jsu_pkg::PH_BODY;
                                    count_next = count_bumped;
                                end
                            end
                            else if (!in_lo)
                            begin
                                phase_next = jsu_pkg::PH_WAIT;
                            end
                            else
                            begin
                                phase_next = jsu_pkg::PH_BODY;
                                count_next = count_bumped;
                            end
                        end
                    end
                end
                jsu_pkg::PH_LOW_BS:
                begin
                    if (!item.end_of_text && item.is_bslash)
                    begin
                        phase_next = jsu_pkg::PH_LOW_U;
                    end
                    else
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                end
                jsu_pkg::PH_LOW_U:
                begin
                    if (!item.end_of_text && item.is_u)
                    begin
                        phase_next = jsu_pkg::PH_LOW_HEX;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                end
                default:
                begin
                    if (!item.end_of_text && item.is_quote)
                    begin
                        phase_next = jsu_pkg::PH_BODY;
                        count_next = '0;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res.decoded_unit  = '0;
        res.decoded_valid = 1'b0;
        res.status        = jsu_pkg::ST_GO;
        case (phase_reg)
            jsu_pkg::PH_BODY:
            begin
                if (plain)
                begin
                    res.decoded_unit  = item.unit;
                    res.decoded_valid = 1'b1;
                end
                else if (too_long)
                begin
                    res.status = jsu_pkg::ST_LONG;
                end
                else if (item.end_of_text)
                begin
                    res.status = jsu_pkg::ST_ENDS;
                end
                else if (item.is_quote)
                begin
                    res.status = jsu_pkg::ST_DONE;
                end
                else if (!item.is_bslash)
                begin
                    res.status = jsu_pkg::ST_CTRL;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                if (item.end_of_text)
                begin
                    res.status = jsu_pkg::ST_ENDS;
                end
                else if (item.is_simple)
                begin
                    res.decoded_unit  = item.simple_unit;
                    res.decoded_valid = 1'b1;
                end
                else if (!item.is_u)
                begin
                    res.status = jsu_pkg::ST_UNSUPPORTED;
                end
            end
            jsu_pkg::PH_HEX:
            begin
                if (!digit_ok)
                begin
                    res.status = jsu_pkg::ST_MALFORMED;
                end
                else if (last_digit)
                begin
                    if (in_lo)
                    begin
                        res.status = jsu_pkg::ST_LONE;
                    end
                    else
                    begin
                        res.decoded_unit  = acc_shift;
                        res.decoded_valid = 1'b1;
                    end
                end
            end
            jsu_pkg::PH_LOW_HEX:
            begin
                if (!digit_ok)
                begin
                    res.status = jsu_pkg::ST_LONE;
                end
                else if (last_digit)
                begin
                    if (!in_lo)
                    begin
                        res.status = jsu_pkg::ST_LONE;
                    end
                    else
                    begin
                        res.decoded_unit  = acc_shift;
                        res.decoded_valid = 1'b1;
                    end
                end
            end
            jsu_pkg::PH_LOW_BS:
            begin
                if (item.end_of_text || !item.is_bslash)
                begin
                    res.status = jsu_pkg::ST_LONE;
                end
            end
            jsu_pkg::PH_LOW_U:
            begin
                if (item.end_of_text || !item.is_u)
                begin
                    res.status = jsu_pkg::ST_LONE;
                end
            end
            default:
            begin
                if (item.end_of_text || !item.is_quote)
                begin
                    res.status = jsu_pkg::ST_NOQUOTE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jsu_pkg::PH_WAIT;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/json_string_unescaper.sv
// Decodes a JSON string literal given as UTF-16 code units, one unit per request.
// Input channel: drive code_unit and end_of_text with push high; the request is
// taken at a rising edge where full is low. Every request yields exactly one
// result (decoded_unit, decoded_valid, status) in the result queue.
// Result channel: while empty is low the oldest result is on the ports; pop high
// at a rising edge takes it.
// A taken request is registered in the classifier queue; the decoder step then
// moves its result into the result queue. Throughput is one request per cycle
// while the result queue is not full, set by the decoder step between the queues.
// Configuration: max_length is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only while no request is in flight.
// Reset clears both queues, sets max_length to 65535 and puts the decoder in its
// wait-for-opening-quote state.
// When the receiver stalls, the result queue fills, then the classifier queue,
// and full rises; nothing is lost or duplicated, and once pop resumes, full drops
// again when the freed result slot lets the decoder step pop the classifier queue.
`default_nettype none

module json_string_unescaper #(
    parameter int unsigned MID_DEPTH = jsu_pkg::MID_DEPTH,
    parameter int unsigned OUT_DEPTH = jsu_pkg::OUT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      decoded_unit,
    output logic             decoded_valid,
    output logic [3:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]    max_length_reg;
    logic [15:0]    max_length_next;
    jsu_pkg::item_t item;
    logic           item_empty;
    logic           item_pop;
    jsu_pkg::res_t  res;
    logic           res_push;
    logic           res_full;
    jsu_pkg::res_t  res_head;

    assign cfg_ready       = 1'b1;
    assign max_length_next = (cfg_valid && cfg_ready) ? cfg_data : max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= jsu_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    jsu_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .item        (item),
        .item_empty  (item_empty),
        .item_pop    (item_pop)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .max_length (max_length_reg),
        .res        (res),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    jsu_fifo #(
        .WIDTH ($bits(jsu_pkg::res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign decoded_unit  = res_head.decoded_unit;
    assign decoded_valid = res_head.decoded_valid;
    assign status        = res_head.status;

endmodule

`default_nettype wire
